/* design/dem_horizon_angle_scan_macros.svh */
// -----------------------------------------------------------------------------
// Assertion macros for the horizon angle scanner
// Shared wrappers that clock every property on clk_i and report through $error.
// -----------------------------------------------------------------------------
`ifndef DEM_HORIZON_ANGLE_SCAN_MACROS_SVH
`define DEM_HORIZON_ANGLE_SCAN_MACROS_SVH

// Checked only while the block is out of reset.
`define DHAS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked at every edge, reset included.
`define DHAS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* design/dhas_pkg.sv */
// -----------------------------------------------------------------------------
// Horizon angle scanner package
// Types, constants and tables shared by the scanner modules.
// -----------------------------------------------------------------------------
package dhas_pkg;

  localparam int unsigned MAX_ROWS = 256;
  localparam int unsigned MAX_COLS = 256;
  localparam int unsigned ADDR_W   = $clog2(MAX_ROWS * MAX_COLS);

  // Raster dimensions and walk positions (positions may sit one cell outside).
  localparam int unsigned DIM_W = 9;
  localparam int unsigned POS_W = 11;
  localparam int unsigned REM_W = 19;

  localparam logic signed [REM_W-1:0] ONE_Q16  = 19'sd65536;
  localparam logic signed [REM_W-1:0] FRAC_Q16 = 19'sd27146;

  localparam logic [14:0] ANGLE_MAX    = 15'd25736;
  localparam int unsigned CORDIC_STEPS = 24;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL = 2'd2;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef struct packed {
    logic              cmd;
    logic [7:0]        row;
    logic [7:0]        col;
    logic signed [15:0] elevation;
    logic [3:0]        direction;
  } item_t;

  typedef struct packed {
    logic [14:0] horizon_angle;
    logic [7:0]  peak_row;
    logic [7:0]  peak_col;
  } result_t;

  typedef struct packed {
    cmd_e              cmd;
    logic [7:0]        row;
    logic [7:0]        col;
    logic signed [15:0] elevation;
    logic [3:0]        direction;
  } entry_t;

  typedef struct packed {
    logic                    start;
    logic [15:0]             rise;
    logic signed [POS_W-1:0] dr;
    logic signed [POS_W-1:0] dc;
  } tan_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] tan;
  } tan_rsp_t;

  typedef struct packed {
    logic        start;
    logic [31:0] tan;
  } atan_req_t;

  typedef struct packed {
    logic        done;
    logic [14:0] angle;
  } atan_rsp_t;

  typedef enum logic [3:0] {
    W_IDLE,
    W_Z0,
    W_Z0L,
    W_CHECK,
    W_EVAL,
    W_TAN,
    W_ADV,
    W_ATAN,
    W_FIN
  } walk_state_e;

  typedef enum logic [2:0] {
    T_IDLE,
    T_D2,
    T_SQRT,
    T_MUL,
    T_DIV,
    T_SAT,
    T_DONE
  } tan_state_e;

  typedef enum logic [1:0] {
    A_IDLE,
    A_RUN,
    A_DONE
  } atan_state_e;

  // Column component of the step vector for each azimuth, Q16.
  function automatic logic signed [REM_W-1:0] step_col(input logic [3:0] dir);
    logic signed [REM_W-1:0] c;
    unique case (dir)
      4'd0, 4'd1, 4'd2, 4'd14, 4'd15: c = ONE_Q16;
      4'd3, 4'd13:                     c = FRAC_Q16;
      4'd4, 4'd12:                     c = '0;
      4'd5, 4'd11:                     c = -FRAC_Q16;
      4'd6, 4'd7, 4'd8, 4'd9, 4'd10:   c = -ONE_Q16;
    endcase
    return c;
  endfunction

  // Row component of the step vector for each azimuth, Q16.
  function automatic logic signed [REM_W-1:0] step_row(input logic [3:0] dir);
    logic signed [REM_W-1:0] c;
    unique case (dir)
      4'd0, 4'd8:                       c = '0;
      4'd1, 4'd7:                       c = FRAC_Q16;
      4'd2, 4'd3, 4'd4, 4'd5, 4'd6:     c = ONE_Q16;
      4'd9, 4'd15:                      c = -FRAC_Q16;
      4'd10, 4'd11, 4'd12, 4'd13, 4'd14: c = -ONE_Q16;
    endcase
    return c;
  endfunction

  // Arctangent of 2^-i in Q2.30.
  function automatic logic signed [33:0] atan_entry(input logic [4:0] i);
    logic signed [33:0] a;
    case (i)
      5'd0:  a = 34'sd843314857;
      5'd1:  a = 34'sd497837830;
      5'd2:  a = 34'sd263043837;
      5'd3:  a = 34'sd133525159;
      5'd4:  a = 34'sd67021687;
      5'd5:  a = 34'sd33543516;
      5'd6:  a = 34'sd16775851;
      5'd7:  a = 34'sd8388437;
      5'd8:  a = 34'sd4194283;
      5'd9:  a = 34'sd2097149;
      5'd10: a = 34'sd1048576;
      5'd11: a = 34'sd524288;
      5'd12: a = 34'sd262144;
      5'd13: a = 34'sd131072;
      5'd14: a = 34'sd65536;
      5'd15: a = 34'sd32768;
      5'd16: a = 34'sd16384;
      5'd17: a = 34'sd8192;
      5'd18: a = 34'sd4096;
      5'd19: a = 34'sd2048;
      5'd20: a = 34'sd1024;
      5'd21: a = 34'sd512;
      5'd22: a = 34'sd256;
      5'd23: a = 34'sd128;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

/* design/dhas_front.sv */
// -----------------------------------------------------------------------------
// Horizon angle scanner front end
// Accepts command beats, classifies them and holds them in a two-entry queue.
// -----------------------------------------------------------------------------
module dhas_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  dhas_pkg::item_t item_i,
  output logic            busy,
  input  logic            pop_i,
  output logic            ent_valid_o,
  output dhas_pkg::entry_t ent_o
);
  import dhas_pkg::*;

  localparam int unsigned QDEPTH = 2;

  entry_t     slot_q [QDEPTH];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;
  entry_t     ent_in;

  always_comb begin
    ent_in.cmd       = item_i.cmd ? CMD_QUERY : CMD_LOAD;
    ent_in.row       = item_i.row;
    ent_in.col       = item_i.col;
    ent_in.elevation = item_i.elevation;
    ent_in.direction = item_i.direction;
  end

  assign busy        = (cnt_q == 2'(QDEPTH));
  assign push        = start && !busy;
  assign ent_valid_o = (cnt_q != 2'd0);
  assign pop         = pop_i && ent_valid_o;
  assign ent_o       = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= ent_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule

/* design/dhas_tan.sv */
// -----------------------------------------------------------------------------
// Horizon angle scanner slope unit
// Forms rise / (cell_size * distance) in Q16.16 with a bit-serial root and divide.
// -----------------------------------------------------------------------------
module dhas_tan (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [15:0]        cell_size_i,
  input  dhas_pkg::tan_req_t req_i,
  output dhas_pkg::tan_rsp_t rsp_o
);
  import dhas_pkg::*;

  tan_state_e state_q, state_d;

  logic signed [POS_W-1:0]   dr_q, dc_q;
  logic [15:0]               rise_q;
  logic [36:0]               v_q, r_q, bit_q;
  logic [33:0]               den_q;
  logic [39:0]               num_q, quo_q;
  logic [33:0]               rem_q;
  logic [5:0]                cnt_q;
  logic [31:0]               tan_q;
  logic signed [2*POS_W-1:0] sq_r, sq_c;
  logic [36:0]               d2, trial;
  logic [34:0]               rem_sh;
  logic                      fits;

  assign sq_r   = dr_q * dr_q;
  assign sq_c   = dc_q * dc_q;
  assign d2     = 37'(unsigned'(sq_r)) + 37'(unsigned'(sq_c));
  assign trial  = r_q + bit_q;
  assign rem_sh = {rem_q, num_q[39]};
  assign fits   = (rem_sh >= {1'b0, den_q});

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      T_IDLE: if (req_i.start) state_d = T_D2;
      T_D2:   state_d = T_SQRT;
      T_SQRT: if (bit_q == 37'd1) state_d = T_MUL;
      T_MUL:  state_d = T_DIV;
      T_DIV: begin
        if (den_q == '0) state_d = T_DONE;
        else if (cnt_q == 6'd39) state_d = T_SAT;
      end
      T_SAT:  state_d = T_DONE;
      T_DONE: state_d = T_IDLE;
      default: state_d = T_IDLE;
    endcase
  end

  always_comb begin
    rsp_o.done = (state_q == T_DONE);
    rsp_o.tan  = tan_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      T_IDLE: begin
        if (req_i.start) begin
          dr_q   <= req_i.dr;
          dc_q   <= req_i.dc;
          rise_q <= req_i.rise;
        end
      end
      T_D2: begin
        v_q   <= d2 << 16;
        r_q   <= '0;
        bit_q <= 37'd1 << 34;
      end
      T_SQRT: begin
        if (v_q >= trial) begin
          v_q <= v_q - trial;
          r_q <= (r_q >> 1) + bit_q;
        end else begin
          r_q <= r_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      T_MUL: begin
        den_q <= 34'(cell_size_i) * 34'(r_q[17:0]);
        num_q <= {rise_q, 24'd0};
        rem_q <= '0;
        quo_q <= '0;
        cnt_q <= '0;
      end
      T_DIV: begin
        if (den_q == '0) begin
          tan_q <= '1;
        end else begin
          rem_q <= fits ? 34'(rem_sh - {1'b0, den_q}) : rem_sh[33:0];
          quo_q <= {quo_q[38:0], fits};
          num_q <= num_q << 1;
          cnt_q <= cnt_q + 6'd1;
        end
      end
      T_SAT:  tan_q <= (|quo_q[39:32]) ? '1 : quo_q[31:0];
      T_DONE: ;
      default: ;
    endcase
  end

endmodule

/* design/dhas_atan.sv */
// -----------------------------------------------------------------------------
// Horizon angle scanner arctangent unit
// Iterative 24-step CORDIC in vectoring mode, one rotation per cycle.
// -----------------------------------------------------------------------------
module dhas_atan (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dhas_pkg::atan_req_t req_i,
  output dhas_pkg::atan_rsp_t rsp_o
);
  import dhas_pkg::*;

  atan_state_e state_q, state_d;

  logic signed [51:0] x_q, y_q, xs, ys;
  logic signed [33:0] z_q, zc;
  logic [4:0]         i_q;
  logic [33:0]        q;

  assign xs = x_q >>> i_q;
  assign ys = y_q >>> i_q;
  assign zc = z_q[33] ? '0 : z_q;
  assign q  = (unsigned'(zc) + 34'd32768) >> 16;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      A_IDLE: if (req_i.start) state_d = A_RUN;
      A_RUN:  if (i_q == 5'(CORDIC_STEPS - 1)) state_d = A_DONE;
      A_DONE: state_d = A_IDLE;
      default: state_d = A_IDLE;
    endcase
  end

  always_comb begin
    rsp_o.done  = (state_q == A_DONE);
    rsp_o.angle = (q > 34'(ANGLE_MAX)) ? ANGLE_MAX : q[14:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == A_IDLE && req_i.start) begin
      x_q <= 52'sd1 <<< 32;
      y_q <= $signed(52'({req_i.tan, 16'd0}));
      z_q <= '0;
      i_q <= '0;
    end else if (state_q == A_RUN) begin
      if (!y_q[51]) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + atan_entry(i_q);
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - atan_entry(i_q);
      end
      i_q <= i_q + 5'd1;
    end
  end

endmodule

/* design/dhas_walk.sv */
// -----------------------------------------------------------------------------
// Horizon angle scanner back end
// Holds the elevation raster, runs loads and walks each query along its azimuth.
// -----------------------------------------------------------------------------
module dhas_walk (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 ent_valid_i,
  input  dhas_pkg::entry_t     ent_i,
  output logic                 pop_o,
  input  logic [8:0]           nrows_i,
  input  logic [8:0]           ncols_i,
  output dhas_pkg::tan_req_t   tan_req_o,
  input  dhas_pkg::tan_rsp_t   tan_rsp_i,
  output dhas_pkg::atan_req_t  atan_req_o,
  input  dhas_pkg::atan_rsp_t  atan_rsp_i,
  output logic                 result_valid_o,
  output dhas_pkg::result_t    result_o
);
  import dhas_pkg::*;

  walk_state_e state_q, state_d;

  logic signed [15:0]       mem [MAX_ROWS * MAX_COLS];
  logic signed [15:0]       rd_q;
  logic [ADDR_W-1:0]        rd_addr, wr_addr;
  logic                     mem_we;

  logic [7:0]               row0_q, col0_q, pkr_q, pkc_q;
  logic [3:0]               dir_q;
  logic signed [POS_W-1:0]  k_q, l_q, k_next, l_next;
  logic signed [REM_W-1:0]  remr_q, remc_q, rsum, csum, rnew, cnew;
  logic signed [15:0]       z0_q;
  logic [31:0]              max_q;
  logic [14:0]              angle_q;
  logic                     res_valid_q;
  result_t                  res_q;

  logic signed [16:0]       rise;
  logic                     rise_pos, in_rng, q_in_rng, load_ok;

  // Next position: add the component to the remainder, then test it.
  always_comb begin
    rsum = ((state_q == W_Z0L) ? '0 : remr_q) + step_row(dir_q);
    csum = ((state_q == W_Z0L) ? '0 : remc_q) + step_col(dir_q);
    rnew   = rsum;
    cnew   = csum;
    k_next = k_q;
    l_next = l_q;
    if (rsum >= ONE_Q16) begin
      rnew = rsum - ONE_Q16;  k_next = k_q + 11'sd1;
    end else if (rsum <= -ONE_Q16) begin
      rnew = rsum + ONE_Q16;  k_next = k_q - 11'sd1;
    end
    if (csum >= ONE_Q16) begin
      cnew = csum - ONE_Q16;  l_next = l_q + 11'sd1;
    end else if (csum <= -ONE_Q16) begin
      cnew = csum + ONE_Q16;  l_next = l_q - 11'sd1;
    end
  end

  assign in_rng = !k_q[POS_W-1] && !l_q[POS_W-1]
               && (k_q < $signed({2'b00, nrows_i}))
               && (l_q < $signed({2'b00, ncols_i}));
  assign q_in_rng = ({1'b0, ent_i.row} < nrows_i) && ({1'b0, ent_i.col} < ncols_i);
  assign load_ok  = (32'(ent_i.row) < MAX_ROWS) && (32'(ent_i.col) < MAX_COLS);
  assign rise     = {rd_q[15], rd_q} - {z0_q[15], z0_q};
  assign rise_pos = !rise[16] && (rise != '0);

  assign rd_addr = ADDR_W'(ADDR_W'(k_q[DIM_W-1:0]) * ADDR_W'(MAX_COLS)
                 + ADDR_W'(l_q[DIM_W-1:0]));
  assign wr_addr = ADDR_W'(ADDR_W'(ent_i.row) * ADDR_W'(MAX_COLS) + ADDR_W'(ent_i.col));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= ent_i.elevation;
    end
    rd_q <= mem[rd_addr];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      W_IDLE: begin
        if (ent_valid_i && ent_i.cmd == CMD_QUERY) begin
          state_d = q_in_rng ? W_Z0 : W_FIN;
        end
      end
      W_Z0:   state_d = W_Z0L;
      W_Z0L:  state_d = W_CHECK;
      W_CHECK: begin
        if (in_rng)              state_d = W_EVAL;
        else if (max_q != '0)    state_d = W_ATAN;
        else                     state_d = W_FIN;
      end
      W_EVAL: state_d = rise_pos ? W_TAN : W_ADV;
      W_TAN:  if (tan_rsp_i.done) state_d = W_ADV;
      W_ADV:  state_d = W_CHECK;
      W_ATAN: if (atan_rsp_i.done) state_d = W_FIN;
      W_FIN:  state_d = W_IDLE;
      default: state_d = W_IDLE;
    endcase
  end

  always_comb begin
    pop_o            = (state_q == W_IDLE) && ent_valid_i;
    mem_we           = pop_o && (ent_i.cmd == CMD_LOAD) && load_ok;
    tan_req_o.start  = (state_q == W_EVAL) && rise_pos;
    tan_req_o.rise   = rise[15:0];
    tan_req_o.dr     = k_q - $signed({3'b000, row0_q});
    tan_req_o.dc     = l_q - $signed({3'b000, col0_q});
    atan_req_o.start = (state_q == W_CHECK) && !in_rng && (max_q != '0);
    atan_req_o.tan   = max_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= W_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= (state_q == W_FIN);
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      W_IDLE: begin
        if (ent_valid_i && ent_i.cmd == CMD_QUERY) begin
          row0_q <= ent_i.row;
          col0_q <= ent_i.col;
          dir_q  <= ent_i.direction;
          k_q    <= $signed({3'b000, ent_i.row});
          l_q    <= $signed({3'b000, ent_i.col});
          max_q  <= '0;
          pkr_q  <= ent_i.row;
          pkc_q  <= ent_i.col;
        end
      end
      W_Z0L: begin
        z0_q   <= rd_q;
        remr_q <= rnew;
        remc_q <= cnew;
        k_q    <= k_next;
        l_q    <= l_next;
      end
      W_ADV: begin
        remr_q <= rnew;
        remc_q <= cnew;
        k_q    <= k_next;
        l_q    <= l_next;
      end
      W_TAN: begin
        if (tan_rsp_i.done && tan_rsp_i.tan > max_q) begin
          max_q <= tan_rsp_i.tan;
          pkr_q <= k_q[7:0];
          pkc_q <= l_q[7:0];
        end
      end
      W_ATAN: if (atan_rsp_i.done) angle_q <= atan_rsp_i.angle;
      W_FIN: begin
        res_q.horizon_angle <= (max_q == '0) ? '0 : angle_q;
        res_q.peak_row      <= pkr_q;
        res_q.peak_col      <= pkc_q;
      end
      W_Z0, W_CHECK, W_EVAL: ;
      default: ;
    endcase
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

/* design/dem_horizon_angle_scan.sv */
// -----------------------------------------------------------------------------
// Horizon angle scanner top level
// Raster elevation store with a horizon angle search along one of 16 azimuths per query.
// -----------------------------------------------------------------------------
// How the block is used:
// Command beats enter on item_i at a clock edge where start is high and busy is
// low. A load beat (cmd 0) writes one signed elevation into the raster store and
// produces no result. A query beat (cmd 1) walks outward from the named cell
// along one of 16 azimuths and produces exactly one result beat on result_o,
// marked by result_valid_o for a single cycle; the receiver cannot stall it.
// Beats pass through a two-entry queue, so busy rises only when both entries
// are taken while the back end is still working.
// Order of work: a load is written into the store as it leaves the queue. A
// query visits each cell through a check, an evaluate and an advance step;
// each visited cell that rises above the query cell also runs an 18-step root
// and a 40-step divide in the shared slope unit, and the CORDIC arctangent
// runs at the end when the largest slope found is not zero. On a long walk
// over rising terrain the slope unit sets the run time.
// Configuration beats (rows, columns, cell size) are always accepted and must
// only be sent while the block is idle. Reset clears the queue, the control
// state and the registers to 256 rows, 256 columns and a 300 decimeter cell;
// the elevation store is not cleared and each cell must be loaded before use.
// -----------------------------------------------------------------------------
module dem_horizon_angle_scan (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  dhas_pkg::item_t                    item_i,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [dhas_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [15:0]                        cfg_data_i,
  output logic                               result_valid_o,
  output dhas_pkg::result_t                  result_o
);
  import dhas_pkg::*;

  logic [DIM_W-1:0] rows_q, cols_q, nrows, ncols;
  logic [15:0]      cell_q;

  logic      pop, ent_valid;
  entry_t    ent;
  tan_req_t  tan_req;
  tan_rsp_t  tan_rsp;
  atan_req_t atan_req;
  atan_rsp_t atan_rsp;

  // The configuration channel never pushes back.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= 9'd256;
      cols_q <= 9'd256;
      cell_q <= 16'd300;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_ROWS: rows_q <= cfg_data_i[DIM_W-1:0];
        CFG_COLS: cols_q <= cfg_data_i[DIM_W-1:0];
        CFG_CELL: cell_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A raster larger than the store is taken at the store's size.
  assign nrows = (32'(rows_q) > MAX_ROWS) ? DIM_W'(MAX_ROWS) : rows_q;
  assign ncols = (32'(cols_q) > MAX_COLS) ? DIM_W'(MAX_COLS) : cols_q;

  dhas_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .item_i      (item_i),
    .busy        (busy),
    .pop_i       (pop),
    .ent_valid_o (ent_valid),
    .ent_o       (ent)
  );

  dhas_walk u_walk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ent_valid_i    (ent_valid),
    .ent_i          (ent),
    .pop_o          (pop),
    .nrows_i        (nrows),
    .ncols_i        (ncols),
    .tan_req_o      (tan_req),
    .tan_rsp_i      (tan_rsp),
    .atan_req_o     (atan_req),
    .atan_rsp_i     (atan_rsp),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  dhas_tan u_tan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cell_size_i (cell_q),
    .req_i       (tan_req),
    .rsp_o       (tan_rsp)
  );

  dhas_atan u_atan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (atan_req),
    .rsp_o  (atan_rsp)
  );

endmodule

/* design/dhas_checker.sv */
// -----------------------------------------------------------------------------
// Horizon angle scanner port checker
// Watches the top-level ports for result strobe, range and busy behavior.
// -----------------------------------------------------------------------------
`include "dem_horizon_angle_scan_macros.svh"

module dhas_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              result_valid_o,
  input dhas_pkg::result_t result_o
);
  import dhas_pkg::*;

  // Every query passes through the idle state after its finish, so strobes never touch.
  `DHAS_ASSERT(a_strobe_single, result_valid_o |=> !result_valid_o, "back to back result strobes")

  `DHAS_ASSERT(a_angle_range, result_valid_o |-> result_o.horizon_angle <= ANGLE_MAX, "angle out of range")

  // The queue fills only by accepting a beat.
  `DHAS_ASSERT(a_busy_needs_push, !busy && !start |=> !busy, "busy rose without an accepted beat")

  `DHAS_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !busy && !result_valid_o, "outputs active in reset")

endmodule

bind dem_horizon_angle_scan dhas_checker u_dhas_checker (.*);

/* test/testbench.sv */
// -----------------------------------------------------------------------------
// Horizon angle scanner testbench
// Drives load and query beats with random gaps through a queue-fed driver and
// checks every result beat against a cycle-free prediction of the walk, the
// slope arithmetic and the CORDIC arctangent.
// -----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dhas_pkg::*;

  localparam int LIMIT_CYCLES = 4000000;
  localparam int SETTLE_CYCLES = 40;
  // The register list has three entries; index 3 lands on nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int Q16_ONE = 65536;
  localparam int Q16_FRAC = 27146;

  // Column and row components of the step vector per azimuth, Q16.
  localparam int AZ_COL[16] = '{Q16_ONE, Q16_ONE, Q16_ONE, Q16_FRAC, 0, -Q16_FRAC,
    -Q16_ONE, -Q16_ONE, -Q16_ONE, -Q16_ONE, -Q16_ONE, -Q16_FRAC, 0, Q16_FRAC,
    Q16_ONE, Q16_ONE};
  localparam int AZ_ROW[16] = '{0, Q16_FRAC, Q16_ONE, Q16_ONE, Q16_ONE, Q16_ONE,
    Q16_ONE, Q16_FRAC, 0, -Q16_FRAC, -Q16_ONE, -Q16_ONE, -Q16_ONE, -Q16_ONE,
    -Q16_ONE, -Q16_FRAC};
  // Arctangent of 2^-i in Q2.30.
  localparam longint ATAN_Q30[24] = '{843314857, 497837830, 263043837, 133525159,
    67021687, 33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128};

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  item_t item_i;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [15:0] cfg_data_i;
  logic result_valid_o;
  result_t result_o;

  dem_horizon_angle_scan dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .item_i(item_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i),
    .result_valid_o(result_valid_o),
    .result_o(result_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Shadow of the block: raster contents and register values as the block
  // should hold them after every accepted beat.
  logic signed [15:0] shadow_elev [65536];
  logic [8:0] shadow_rows = 9'd256;
  logic [8:0] shadow_cols = 9'd256;
  logic [15:0] shadow_cell = 16'd300;

  // Cells that the stimulus has already scheduled a load for. A query is only
  // ever queued after every cell it can read has a load ahead of it.
  bit loaded_plan [65536];

  item_t pending_q[$];
  result_t horizon_q[$];
  int gap_left;
  bit calm;

  int errors;
  int n_loads, n_queries, n_checked, n_steep, n_cfg;
  int cycle_count;

  task automatic report(string what, int got, int want);
    $display("mismatch on %s: got %0d, expected %0d (t=%0t)", what, got, want, $time);
    errors++;
  endtask

  function automatic int clamp_dim(logic [8:0] v);
    return (v > 9'd256) ? 256 : int'(v);
  endfunction

  function automatic int axis_step(ref int rem);
    if (rem >= Q16_ONE) begin
      rem -= Q16_ONE;
      return 1;
    end
    if (rem <= -Q16_ONE) begin
      rem += Q16_ONE;
      return -1;
    end
    return 0;
  endfunction

  // Lists the cells a walk visits, in order, until it leaves the raster.
  function automatic void walk_cells(int r, int c, int dir, int nr, int nc,
                                     ref int kr[$], ref int kc[$]);
    int rem_r;
    int rem_c;
    int k;
    int l;
    kr.delete();
    kc.delete();
    rem_r = AZ_ROW[dir];
    rem_c = AZ_COL[dir];
    k = r + axis_step(rem_r);
    l = c + axis_step(rem_c);
    while (k >= 0 && k < nr && l >= 0 && l < nc) begin
      kr.push_back(k);
      kc.push_back(l);
      rem_r += AZ_ROW[dir];
      rem_c += AZ_COL[dir];
      k += axis_step(rem_r);
      l += axis_step(rem_c);
    end
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Slope tangent in Q16.16 for a positive rise at offset (dr, dc).
  function automatic logic [31:0] slope_q16(int rise, int dr, int dc);
    longint unsigned d2;
    longint unsigned dist_q8;
    longint unsigned den;
    longint unsigned t;
    d2 = longint'(dr) * dr + longint'(dc) * dc;
    dist_q8 = int_sqrt(d2 << 16);
    den = longint'(shadow_cell) * dist_q8;
    if (den == 0) return 32'hFFFF_FFFF;
    t = (longint'(rise) << 24) / den;
    if (t > 64'hFFFF_FFFF) return 32'hFFFF_FFFF;
    return t[31:0];
  endfunction

  // CORDIC vectoring, then rounding to Q2.14 with clamps at both ends.
  function automatic logic [14:0] angle_q14(logic [31:0] tan_q16);
    longint x;
    longint y;
    longint z;
    longint xs;
    longint ys;
    longint q;
    x = 64'sd1 <<< 32;
    y = longint'({32'd0, tan_q16}) <<< 16;
    z = 0;
    for (int i = 0; i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys;
        y -= xs;
        z += ATAN_Q30[i];
      end else begin
        x -= ys;
        y += xs;
        z -= ATAN_Q30[i];
      end
    end
    if (z < 0) z = 0;
    q = (z + 32768) >>> 16;
    if (q > longint'(ANGLE_MAX)) q = ANGLE_MAX;
    return q[14:0];
  endfunction

  // Applies one accepted beat to the shadow and queues the result it owes.
  function automatic void horizon_predict(item_t it);
    int nr;
    int nc;
    int kr[$];
    int kc[$];
    int z0;
    int rise;
    logic [31:0] best;
    logic [31:0] t;
    result_t res;
    if (it.cmd == CMD_LOAD) begin
      shadow_elev[{it.row, it.col}] = it.elevation;
      n_loads++;
      return;
    end
    n_queries++;
    nr = clamp_dim(shadow_rows);
    nc = clamp_dim(shadow_cols);
    best = '0;
    res.peak_row = it.row;
    res.peak_col = it.col;
    if (int'(it.row) < nr && int'(it.col) < nc) begin
      z0 = shadow_elev[{it.row, it.col}];
      walk_cells(it.row, it.col, it.direction, nr, nc, kr, kc);
      foreach (kr[i]) begin
        rise = int'(shadow_elev[{kr[i][7:0], kc[i][7:0]}]) - z0;
        if (rise > 0) begin
          t = slope_q16(rise, kr[i] - int'(it.row), kc[i] - int'(it.col));
          if (t > best) begin
            best = t;
            res.peak_row = kr[i][7:0];
            res.peak_col = kc[i][7:0];
          end
        end
      end
    end
    res.horizon_angle = (best == 0) ? 15'd0 : angle_q14(best);
    if (res.horizon_angle != 0) n_steep++;
    horizon_q.push_back(res);
  endfunction

  // Mostly short gaps, now and then a long one; none at all in a calm phase.
  function automatic int pick_gap();
    int k;
    if (calm) return 0;
    k = $urandom_range(0, 19);
    if (k < 12) return 0;
    if (k < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Driver: a beat is accepted at an edge where start is high and busy low.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      item_i <= '0;
      gap_left <= 0;
    end else begin
      if (start && !busy) horizon_predict(item_i);
      if (start && busy) begin
        // Hold the beat until the block takes it.
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_q.size() > 0) begin
        item_i <= pending_q.pop_front();
        start <= 1'b1;
        gap_left <= pick_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every result beat is checked against the oldest prediction.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && result_valid_o) begin
      if (horizon_q.size() == 0) begin
        $display("result beat with no query outstanding (t=%0t)", $time);
        errors++;
      end else begin
        want = horizon_q.pop_front();
        n_checked++;
        if (result_o.horizon_angle !== want.horizon_angle)
          report("horizon_angle", result_o.horizon_angle, want.horizon_angle);
        if (result_o.peak_row !== want.peak_row)
          report("peak_row", result_o.peak_row, want.peak_row);
        if (result_o.peak_col !== want.peak_col)
          report("peak_col", result_o.peak_col, want.peak_col);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout with %0d results outstanding", horizon_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic signed [15:0] pick_elev();
    int k;
    k = $urandom_range(0, 9);
    if (k < 6) return 16'($urandom_range(0, 1200)) - 16'sd400;
    if (k < 8) return 16'($urandom);
    if (k == 8) return 16'sh7FFF;
    return 16'sh8000;
  endfunction

  task automatic queue_load(int r, int c, logic signed [15:0] e);
    item_t it;
    it = '0;
    it.cmd = CMD_LOAD;
    it.row = r[7:0];
    it.col = c[7:0];
    it.elevation = e;
    it.direction = 4'($urandom);
    loaded_plan[{it.row, it.col}] = 1'b1;
    pending_q.push_back(it);
  endtask

  // Queues a query, preceded by loads for any cell it reads that is still
  // unwritten, so that no read of an unwritten store entry can happen.
  task automatic queue_query(int r, int c, int dir, int nr, int nc);
    item_t it;
    int kr[$];
    int kc[$];
    if (r < nr && c < nc) begin
      if (!loaded_plan[{r[7:0], c[7:0]}]) queue_load(r, c, pick_elev());
      walk_cells(r, c, dir, nr, nc, kr, kc);
      foreach (kr[i])
        if (!loaded_plan[{kr[i][7:0], kc[i][7:0]}]) queue_load(kr[i], kc[i], pick_elev());
    end
    it.cmd = CMD_QUERY;
    it.row = r[7:0];
    it.col = c[7:0];
    it.elevation = 16'($urandom);
    it.direction = dir[3:0];
    pending_q.push_back(it);
  endtask

  // Waits until every beat is in and answered, then lets a load that is
  // still being written finish before the registers change.
  task automatic wait_idle();
    while (pending_q.size() != 0 || start || horizon_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes all registers in one burst; valid stays high across the burst.
  task automatic write_regs(logic [8:0] rows, logic [8:0] cols, logic [15:0] cell_dm);
    logic [CFG_IDX_W-1:0] idx [4];
    logic [15:0] dat [4];
    idx = '{CFG_SPARE, CFG_ROWS, CFG_COLS, CFG_CELL};
    dat = '{16'($urandom), {7'd0, rows}, {7'd0, cols}, cell_dm};
    wait_idle();
    for (int i = 0; i < 4; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i <= dat[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      n_cfg++;
      case (idx[i])
        CFG_ROWS: shadow_rows = dat[i][8:0];
        CFG_COLS: shadow_cols = dat[i][8:0];
        CFG_CELL: shadow_cell = dat[i];
        default: ;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  // One random phase: mostly queries over a filled-in walk, some plain loads
  // anywhere in the store and some queries that miss the raster.
  task automatic run_phase(logic [8:0] rows, logic [8:0] cols, logic [15:0] cell_dm,
                           int n_beats, int max_walk, bit quiet);
    int nr;
    int nc;
    int base;
    int r;
    int c;
    int dir;
    int tries;
    int kr[$];
    int kc[$];
    write_regs(rows, cols, cell_dm);
    calm = quiet;
    nr = clamp_dim(rows);
    nc = clamp_dim(cols);
    base = pending_q.size() + n_loads + n_queries;
    while (pending_q.size() + n_loads + n_queries - base < n_beats) begin
      if ($urandom_range(0, 99) < 25) begin
        if ($urandom_range(0, 3) == 0 || nr == 0 || nc == 0)
          queue_load($urandom_range(0, 255), $urandom_range(0, 255), pick_elev());
        else
          queue_load($urandom_range(0, nr - 1), $urandom_range(0, nc - 1), pick_elev());
      end else if (nr == 0 || nc == 0 || ((nr < 256 || nc < 256) &&
                   $urandom_range(0, 9) == 0)) begin
        r = (nr < 256) ? $urandom_range(nr, 255) : $urandom_range(0, 255);
        c = (nr < 256) ? $urandom_range(0, 255) : $urandom_range(nc, 255);
        queue_query(r, c, $urandom_range(0, 15), nr, nc);
      end else begin
        tries = 0;
        do begin
          r = $urandom_range(0, nr - 1);
          c = $urandom_range(0, nc - 1);
          dir = $urandom_range(0, 15);
          walk_cells(r, c, dir, nr, nc, kr, kc);
          tries++;
        end while (kr.size() > max_walk && tries < 200);
        if (kr.size() > max_walk) begin
          // Fall back to the far corner heading out, which visits no cell.
          r = nr - 1;
          c = nc - 1;
          dir = 0;
        end
        queue_query(r, c, dir, nr, nc);
      end
    end
  endtask

  initial begin
    int dir_list[$];
    rst_ni = 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CFG_ROWS;
    cfg_data_i <= '0;
    calm = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part on a 6 by 7 raster with a one decimeter cell: a flat field
    // with a deep pit at the center and the highest peak in a corner, so the
    // center sees a rise in every azimuth, the peak sees nothing, and the
    // steepest tangents come close to the top of the angle range.
    write_regs(9'd6, 9'd7, 16'd1);
    for (int r = 0; r < 6; r++)
      for (int c = 0; c < 7; c++)
        queue_load(r, c, (r == 3 && c == 3) ? 16'sh8000 :
                         (r == 5 && c == 6) ? 16'sh7FFF :
                         (r == 0 && c == 0) ? 16'sh8000 : 16'sd0);
    for (int d = 0; d < 16; d++) queue_query(3, 3, d, 6, 7);
    queue_query(5, 6, 10, 6, 7);
    queue_query(0, 0, 2, 6, 7);
    queue_query(6, 0, 0, 6, 7);
    queue_query(255, 255, 8, 6, 7);

    // Zero cell size saturates every rising tangent; oversized dimensions
    // fall back to the full raster.
    run_phase(9'd300, 9'd511, 16'd0, 40, 12, 1'b0);
    // Full raster at the largest cell size, with one walk across a whole row.
    write_regs(9'd256, 9'd256, 16'd65535);
    queue_query(128, 0, 0, 256, 256);
    run_phase(9'd256, 9'd256, 16'd65535, 40, 20, 1'b1);
    run_phase(9'd1, 9'd1, 16'd1, 20, 4, 1'b0);
    run_phase(9'd0, 9'd7, 16'd300, 20, 4, 1'b0);
    run_phase(9'd4, 9'd5, 16'd1, 50, 8, 1'b0);
    for (int p = 0; p < 3; p++)
      run_phase(9'($urandom_range(8, 16)), 9'($urandom_range(8, 16)),
                16'($urandom_range(50, 2000)), 40, 16, p == 1);

    wait_idle();
    repeat (100) @(posedge clk_i);
    $display("covered %0d loads and %0d queries over %0d register writes",
             n_loads, n_queries, n_cfg);
    $display("checked %0d results, %0d of them with a rising horizon",
             n_checked, n_steep);
    if (errors == 0 && horizon_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results never arrived", errors, horizon_q.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
